@@ hw/rtl/msam_pkg.sv @@
// Package for the stepping audio mixer: default sizes, operation codes,
// the per-voice state word and the divide-by-127 constants.
// No dependencies.
package msam_pkg;

  localparam int VOICES_DEFAULT      = 8;
  localparam int STORE_DEPTH_DEFAULT = 65536;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // floor(x/127) == (x*DIV127_MULT) >> DIV127_SHIFT for x < 2^15
  localparam logic [15:0] DIV127_MULT  = 16'd33027;
  localparam int          DIV127_SHIFT = 22;

  localparam int POS_W  = 17;
  localparam int FRAC_W = 16;
  localparam int STEP_W = 18;
  localparam int GAIN_W = 7;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [FRAC_W-1:0] fraction;
    logic [POS_W-1:0]  end_addr;
    logic [STEP_W-1:0] step;
    logic [GAIN_W-1:0] left_gain;
    logic [GAIN_W-1:0] right_gain;
  } voice_t;

endpackage

@@ hw/rtl/msam_if.sv @@
// Valid/ready channel interfaces for the mixer: input items and results.
// No dependencies.
interface msam_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [2:0]  voice;
  logic [15:0] address;
  logic [7:0]  sample_byte;
  logic [16:0] end_address;
  logic [17:0] step;
  logic [6:0]  volume;
  logic [7:0]  separation;

  modport source (output valid, opcode, voice, address, sample_byte, end_address, step,
                  volume, separation, input ready);
  modport sink (input valid, opcode, voice, address, sample_byte, end_address, step,
                volume, separation, output ready);
endinterface

interface msam_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic [7:0]         active_mask;

  modport source (output valid, left_sample, right_sample, active_mask, input ready);
  modport sink (input valid, left_sample, right_sample, active_mask, output ready);
endinterface

@@ hw/rtl/msam_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module msam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/multichannel_stepping_audio_mixer.sv @@
// Stepping PCM mixer top level: sample store, voice state RAM, tick sequencer.
// Depends on msam_pkg, msam_if (msam_in_if, msam_out_if) and msam_ram.
//
// Load transactions write one byte into the sample store and start transactions
// program one voice through ST_START_SQ and ST_START_WR. A tick walks the voices in
// index order: an inactive voice is only checked in ST_SCAN, an active one goes
// through the steps voice RAM read, sample store read, gain multiply, divide by
// 127 and accumulate, one per state. The result register is separate from the input
// side, so loads and starts are taken while a mix result waits. SAMPLE_STORE_DEPTH
// must be a power of two; store addresses wrap modulo the depth. The store has no
// reset.
module multichannel_stepping_audio_mixer
  import msam_pkg::*;
#(
  parameter int VOICES             = VOICES_DEFAULT,
  parameter int SAMPLE_STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  msam_in_if.sink     item,
  msam_out_if.source  result
);

  localparam int VW     = VOICES > 1 ? $clog2(VOICES) : 1;
  localparam int VX_W   = VW > 3 ? VW : 3;
  localparam int SA_W   = $clog2(SAMPLE_STORE_DEPTH);
  localparam int EXT_W  = SA_W > POS_W ? SA_W : POS_W;
  localparam int LA_W   = SA_W > 16 ? SA_W : 16;
  localparam int SUM_W  = 18 + $clog2(VOICES);
  localparam int VD_W   = $bits(voice_t);

  typedef enum logic [3:0] {
    ST_IDLE, ST_START_SQ, ST_START_WR, ST_SCAN, ST_VOICE, ST_SAMP, ST_DIV, ST_ACC,
    ST_DONE
  } state_t;

  state_t state;

  logic [VOICES-1:0] active;
  logic [VW-1:0]     cur;

  logic [VW-1:0]     st_voice;
  logic [15:0]       st_address;
  logic [16:0]       st_end;
  logic [17:0]       st_step;
  logic [6:0]        st_volume;
  logic [16:0]       sq_left;
  logic [16:0]       sq_right;

  logic [GAIN_W-1:0] gain_left;
  logic [GAIN_W-1:0] gain_right;
  logic [14:0]       prod_left;
  logic [14:0]       prod_right;
  logic              neg;
  logic [16:0]       mag_left;
  logic [16:0]       mag_right;
  logic signed [SUM_W-1:0] sum_left;
  logic signed [SUM_W-1:0] sum_right;

  logic               out_valid;
  logic signed [15:0] out_left;
  logic signed [15:0] out_right;
  logic [7:0]         out_mask;

  // Memory ports
  logic              sram_we;
  logic [SA_W-1:0]   sram_waddr;
  logic [SA_W-1:0]   sram_raddr;
  logic [7:0]        sram_rdata;
  logic              vram_we;
  logic [VW-1:0]     vram_waddr;
  logic [VD_W-1:0]   vram_wdata;
  logic [VD_W-1:0]   vram_rdata;

  msam_ram #(.WIDTH(8), .DEPTH(SAMPLE_STORE_DEPTH)) u_sample_ram (
    .clk   (clk),
    .we    (sram_we),
    .waddr (sram_waddr),
    .wdata (item.sample_byte),
    .raddr (sram_raddr),
    .rdata (sram_rdata)
  );

  msam_ram #(.WIDTH(VD_W), .DEPTH(VOICES)) u_voice_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .raddr (cur),
    .rdata (vram_rdata)
  );

  logic                in_take;
  logic [LA_W-1:0]     load_addr_ext;
  logic [VX_W-1:0]     voice_ext;
  logic                voice_ok;
  voice_t              vd;
  voice_t              vd_new;
  voice_t              vd_start;
  logic [18:0]         acc;
  logic [17:0]         pos;
  logic [EXT_W-1:0]    pos_ext;
  logic [7:0]          smag;
  logic [14:0]         x_left;
  logic [14:0]         x_right;
  logic [30:0]         q_left_full;
  logic [30:0]         q_right_full;
  logic [23:0]         pan_left;
  logic [23:0]         pan_right;
  logic [8:0]          g_left;
  logic [8:0]          g_right;
  logic                last;
  logic signed [SUM_W-1:0] term_left;
  logic signed [SUM_W-1:0] term_right;
  logic [15:0]         sat_left;
  logic [15:0]         sat_right;
  logic [7:0]          mask_now;

  assign in_take       = item.valid && item.ready;
  assign item.ready    = (state == ST_IDLE);
  assign load_addr_ext = LA_W'(item.address);
  assign sram_we       = in_take && (item.opcode == OP_LOAD);
  assign sram_waddr    = load_addr_ext[SA_W-1:0];
  assign voice_ext     = VX_W'(item.voice);
  assign voice_ok      = (32'(item.voice) < 32'(VOICES));

  assign last = (cur == VW'(VOICES - 1));

  // Voice advance
  assign vd      = vram_rdata;
  assign acc     = {3'b0, vd.fraction} + {1'b0, vd.step};
  assign pos     = {1'b0, vd.position} + {15'b0, acc[18:16]};
  assign pos_ext = EXT_W'(vd.position);
  assign sram_raddr = pos_ext[SA_W-1:0];

  always_comb begin
    vd_new          = vd;
    vd_new.position = pos[POS_W-1:0];
    vd_new.fraction = acc[FRAC_W-1:0];
  end

  // Pan rule
  assign pan_left  = 24'(st_volume) * 24'(sq_left);
  assign pan_right = 24'(st_volume) * 24'(sq_right);
  assign g_left    = {2'b0, st_volume} - {1'b0, pan_left[23:16]};
  assign g_right   = {2'b0, st_volume} - {1'b0, pan_right[23:16]};

  always_comb begin
    vd_start.position   = POS_W'(st_address);
    vd_start.fraction   = '0;
    vd_start.end_addr   = st_end;
    vd_start.step       = st_step;
    vd_start.left_gain  = (g_left[8] || g_left[7]) ? '0 : g_left[6:0];
    vd_start.right_gain = (g_right[8] || g_right[7]) ? '0 : g_right[6:0];
  end

  always_comb begin
    vram_we    = 1'b0;
    vram_waddr = cur;
    vram_wdata = vd_new;
    case (state)
      ST_START_WR: begin
        vram_we    = 1'b1;
        vram_waddr = st_voice;
        vram_wdata = vd_start;
      end
      ST_VOICE: begin
        vram_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Scaling: gain*(s-128)*256/127 = sign * (2p + floor(2p/127)), p = gain*|s-128|
  assign smag         = sram_rdata[7] ? {1'b0, sram_rdata[6:0]} : 8'd128 - sram_rdata;
  assign x_left       = {prod_left[13:0], 1'b0};
  assign x_right      = {prod_right[13:0], 1'b0};
  assign q_left_full  = 31'(x_left) * 31'(DIV127_MULT);
  assign q_right_full = 31'(x_right) * 31'(DIV127_MULT);
  assign term_left    = neg ? -SUM_W'(mag_left) : SUM_W'(mag_left);
  assign term_right   = neg ? -SUM_W'(mag_right) : SUM_W'(mag_right);

  always_comb begin
    if (sum_left > SUM_W'(2047)) begin
      sat_left = 16'h7fff;
    end else if (sum_left < -SUM_W'(2048)) begin
      sat_left = 16'h8000;
    end else begin
      sat_left = {sum_left[11:0], 4'b0};
    end
    if (sum_right > SUM_W'(2047)) begin
      sat_right = 16'h7fff;
    end else if (sum_right < -SUM_W'(2048)) begin
      sat_right = 16'h8000;
    end else begin
      sat_right = {sum_right[11:0], 4'b0};
    end
  end

  for (genvar i = 0; i < 8; i++) begin : g_mask
    if (i < VOICES) begin : g_on
      assign mask_now[i] = active[i];
    end else begin : g_off
      assign mask_now[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      active    <= '0;
      cur       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && result.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            st_voice   <= voice_ext[VW-1:0];
            st_address <= item.address;
            st_end     <= item.end_address;
            st_step    <= item.step;
            st_volume  <= item.volume;
            sq_left    <= 17'({1'b0, item.separation} + 9'd1) *
                          17'({1'b0, item.separation} + 9'd1);
            sq_right   <= 17'(9'd256 - {1'b0, item.separation}) *
                          17'(9'd256 - {1'b0, item.separation});
            if (item.opcode == OP_START && voice_ok) begin
              state <= ST_START_SQ;
            end else if (item.opcode == OP_TICK) begin
              cur       <= '0;
              sum_left  <= '0;
              sum_right <= '0;
              state     <= ST_SCAN;
            end
          end
        end
        ST_START_SQ: begin
          state <= ST_START_WR;
        end
        ST_START_WR: begin
          active[st_voice] <= ({1'b0, st_address} < st_end);
          state            <= ST_IDLE;
        end
        ST_SCAN: begin
          if (active[cur]) begin
            state <= ST_VOICE;
          end else if (last) begin
            state <= ST_DONE;
          end else begin
            cur <= cur + VW'(1);
          end
        end
        ST_VOICE: begin
          active[cur] <= (pos < {1'b0, vd.end_addr});
          gain_left   <= vd.left_gain;
          gain_right  <= vd.right_gain;
          state       <= ST_SAMP;
        end
        ST_SAMP: begin
          prod_left  <= 15'(gain_left) * 15'(smag);
          prod_right <= 15'(gain_right) * 15'(smag);
          neg        <= ~sram_rdata[7];
          state      <= ST_DIV;
        end
        ST_DIV: begin
          mag_left  <= 17'(x_left) + 17'(q_left_full[30:DIV127_SHIFT]);
          mag_right <= 17'(x_right) + 17'(q_right_full[30:DIV127_SHIFT]);
          state     <= ST_ACC;
        end
        ST_ACC: begin
          sum_left  <= sum_left + term_left;
          sum_right <= sum_right + term_right;
          if (last) begin
            state <= ST_DONE;
          end else begin
            cur   <= cur + VW'(1);
            state <= ST_SCAN;
          end
        end
        ST_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_left  <= sat_left;
            out_right <= sat_right;
            out_mask  <= mask_now;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign result.valid        = out_valid;
  assign result.left_sample  = out_left;
  assign result.right_sample = out_right;
  assign result.active_mask  = out_mask;

endmodule
